FILE: rtl/drsl_pkg.sv
// ----------------------------------------------------------------------------
// drsl_pkg
// Types and codes shared by the depth region speed limiter.
// ----------------------------------------------------------------------------
package drsl_pkg;

    localparam int DIM_W  = 12;
    localparam int RAT_W  = 9;
    localparam int MM_W   = 16;
    localparam int SPD_W  = 16;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 16;

    typedef enum logic [1:0] {
        CMD_PIXEL = 2'd0,
        CMD_VEL   = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IW-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_ROI_W_RATIO  = 3'd2,
        CFG_ROI_H_RATIO  = 3'd3,
        CFG_STOP_DIST    = 3'd4,
        CFG_SLOW_DIST    = 3'd5,
        CFG_MIN_VALID    = 3'd6,
        CFG_TIMEOUT      = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        RES_REPORT = 1'b0,
        RES_CMD    = 1'b1
    } t_res_kind;

    typedef struct packed {
        logic [1:0]             cmd;
        logic [MM_W-1:0]        depth_mm;
        logic signed [SPD_W-1:0] linear_x_in;
    } t_in_item;

    typedef struct packed {
        logic                    result_kind;
        logic [MM_W-1:0]         nearest_mm;
        logic                    obstacle_seen;
        logic signed [SPD_W-1:0] linear_x_out;
        logic                    forward_stopped;
    } t_out_item;

endpackage

FILE: rtl/depth_roi_speed_limiter.sv
// ----------------------------------------------------------------------------
// depth_roi_speed_limiter
// Tracks the nearest valid depth in a centred region of each frame and
// limits forward speed commands by that distance and its age.
// ----------------------------------------------------------------------------
// A tick or unused code is handled in idle. A pixel passes S_PGEOM, S_PUPD
// if the frame size is nonzero, and S_EMIT if it ends a frame; a command
// passes S_CCHK, then S_CMUL and S_CDIV when scaled (one multiply, 31 divide
// steps through a shift-subtract unit), and S_EMIT, which registers the
// result once the output slot is free. Ready only when idle. Synchronous
// active-low reset restores defaults, clears counters and flags, sets minima to ones.
module depth_roi_speed_limiter #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  drsl_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output drsl_pkg::t_out_item          o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [drsl_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [drsl_pkg::CFG_DW-1:0]  i_cfg_data
);
    import drsl_pkg::*;

    localparam int LIM_W = 14;
    localparam logic [LIM_W-1:0] MAX_W_L = LIM_W'(MAX_WIDTH);
    localparam logic [LIM_W-1:0] MAX_H_L = LIM_W'(MAX_HEIGHT);
    localparam int NUM_W = 31;
    localparam logic [4:0] DIV_LAST = 5'(NUM_W - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_PGEOM, S_PUPD, S_CCHK, S_CMUL, S_CDIV, S_EMIT
    } t_state;

    t_state r_state;

    // configuration
    logic [DIM_W-1:0] r_img_w, r_img_h;
    logic [RAT_W-1:0] r_rat_w, r_rat_h;
    logic [MM_W-1:0]  r_stop, r_slow, r_min_valid, r_timeout;

    // frame state
    logic [DIM_W-1:0] r_col, r_row;
    logic [MM_W-1:0]  r_run_min, r_lat_near, r_ticks;
    logic             r_run_found, r_lat_found, r_frame_seen;

    // item and working registers
    logic [MM_W-1:0]          r_depth;
    logic signed [SPD_W-1:0]  r_lin;
    logic [DIM_W-1:0]         r_roi_w, r_roi_h;
    logic [NUM_W-1:0]         r_num;
    logic [MM_W-1:0]          r_den, r_rem;
    logic [4:0]               r_cnt;
    t_out_item                r_res;
    t_out_item                r_out;
    logic                     r_out_valid;

    // geometry
    logic [DIM_W-1:0]         w_c, h_c;
    logic [DIM_W+RAT_W-1:0]   prod_w, prod_h;
    logic [DIM_W:0]           len_w, len_h;
    logic [DIM_W-1:0]         roi_w, roi_h, x0, y0;
    logic                     in_roi, pix_valid, row_end, frame_end;
    logic [MM_W-1:0]          new_min;

    // command
    logic                     v_pos, depth_fresh;
    logic [MM_W:0]            rem_sh;
    logic                     q_bit;
    logic [MM_W-1:0]          rem_nx;
    logic [NUM_W-1:0]         num_nx;
    logic                     slot_free;

    always_comb begin
        w_c = ({2'b00, r_img_w} > MAX_W_L) ? MAX_W_L[DIM_W-1:0] : r_img_w;
        h_c = ({2'b00, r_img_h} > MAX_H_L) ? MAX_H_L[DIM_W-1:0] : r_img_h;

        prod_w = (DIM_W+RAT_W)'(w_c) * (DIM_W+RAT_W)'(r_rat_w);
        prod_h = (DIM_W+RAT_W)'(h_c) * (DIM_W+RAT_W)'(r_rat_h);
        len_w  = prod_w[DIM_W+RAT_W-1:8];
        len_h  = prod_h[DIM_W+RAT_W-1:8];
        if (len_w == '0) begin
            roi_w = DIM_W'(1);
        end else if (len_w > {1'b0, w_c}) begin
            roi_w = w_c;
        end else begin
            roi_w = len_w[DIM_W-1:0];
        end
        if (len_h == '0) begin
            roi_h = DIM_W'(1);
        end else if (len_h > {1'b0, h_c}) begin
            roi_h = h_c;
        end else begin
            roi_h = len_h[DIM_W-1:0];
        end

        x0 = (w_c - r_roi_w) >> 1;
        y0 = (h_c - r_roi_h) >> 1;
        pix_valid = (r_depth != '0) && (r_depth >= r_min_valid);
        in_roi = (r_col >= x0) && ({1'b0, r_col} < ({1'b0, x0} + {1'b0, r_roi_w}))
              && (r_row >= y0) && ({1'b0, r_row} < ({1'b0, y0} + {1'b0, r_roi_h}));
        new_min = (!r_run_found || r_depth < r_run_min) ? r_depth : r_run_min;
        row_end   = ({1'b0, r_col} + 13'd1) >= {1'b0, w_c};
        frame_end = row_end && (({1'b0, r_row} + 13'd1) >= {1'b0, h_c});

        v_pos       = !r_lin[SPD_W-1] && (r_lin != '0);
        depth_fresh = r_frame_seen && (r_ticks < r_timeout);

        rem_sh = {r_rem, r_num[NUM_W-1]};
        q_bit  = rem_sh >= {1'b0, r_den};
        rem_nx = q_bit ? MM_W'(rem_sh - {1'b0, r_den}) : rem_sh[MM_W-1:0];
        num_nx = {r_num[NUM_W-2:0], q_bit};

        slot_free = !r_out_valid || i_out_ready;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_img_w      <= 12'd640;
            r_img_h      <= 12'd480;
            r_rat_w      <= 9'd102;
            r_rat_h      <= 9'd128;
            r_stop       <= 16'd450;
            r_slow       <= 16'd1000;
            r_min_valid  <= 16'd150;
            r_timeout    <= 16'd1000;
            r_col        <= '0;
            r_row        <= '0;
            r_run_min    <= '1;
            r_run_found  <= 1'b0;
            r_lat_near   <= '1;
            r_lat_found  <= 1'b0;
            r_frame_seen <= 1'b0;
            r_ticks      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_IMAGE_WIDTH:  r_img_w     <= i_cfg_data[DIM_W-1:0];
                    CFG_IMAGE_HEIGHT: r_img_h     <= i_cfg_data[DIM_W-1:0];
                    CFG_ROI_W_RATIO:  r_rat_w     <= i_cfg_data[RAT_W-1:0];
                    CFG_ROI_H_RATIO:  r_rat_h     <= i_cfg_data[RAT_W-1:0];
                    CFG_STOP_DIST:    r_stop      <= i_cfg_data;
                    CFG_SLOW_DIST:    r_slow      <= i_cfg_data;
                    CFG_MIN_VALID:    r_min_valid <= i_cfg_data;
                    CFG_TIMEOUT:      r_timeout   <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_valid && i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_depth <= i_in_data.depth_mm;
                        r_lin   <= i_in_data.linear_x_in;
                        unique case (t_cmd'(i_in_data.cmd))
                            CMD_PIXEL: r_state <= S_PGEOM;
                            CMD_VEL:   r_state <= S_CCHK;
                            CMD_TICK: begin
                                if (r_ticks != '1) begin
                                    r_ticks <= r_ticks + 16'd1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_PGEOM: begin
                    r_roi_w <= roi_w;
                    r_roi_h <= roi_h;
                    r_state <= ((w_c == '0) || (h_c == '0)) ? S_IDLE : S_PUPD;
                end
                S_PUPD: begin
                    r_state <= S_IDLE;
                    if (row_end) begin
                        r_col <= '0;
                        if (frame_end) begin
                            r_row        <= '0;
                            r_lat_found  <= r_run_found || (in_roi && pix_valid);
                            r_lat_near   <= (in_roi && pix_valid) ? new_min : r_run_min;
                            r_frame_seen <= 1'b1;
                            r_ticks      <= '0;
                            r_run_min    <= '1;
                            r_run_found  <= 1'b0;
                            r_res.result_kind     <= RES_REPORT;
                            r_res.nearest_mm      <= (in_roi && pix_valid) ? new_min
                                                                          : r_run_min;
                            r_res.obstacle_seen   <= r_run_found || (in_roi && pix_valid);
                            r_res.linear_x_out    <= '0;
                            r_res.forward_stopped <= 1'b0;
                            r_state               <= S_EMIT;
                        end else begin
                            r_row <= r_row + 12'd1;
                            if (in_roi && pix_valid) begin
                                r_run_min   <= new_min;
                                r_run_found <= 1'b1;
                            end
                        end
                    end else begin
                        r_col <= r_col + 12'd1;
                        if (in_roi && pix_valid) begin
                            r_run_min   <= new_min;
                            r_run_found <= 1'b1;
                        end
                    end
                end
                S_CCHK: begin
                    r_res.result_kind   <= RES_CMD;
                    r_res.nearest_mm    <= '0;
                    r_res.obstacle_seen <= 1'b0;
                    r_state             <= S_EMIT;
                    priority if (!v_pos) begin
                        r_res.linear_x_out    <= r_lin;
                        r_res.forward_stopped <= 1'b0;
                    end else if (!depth_fresh) begin
                        r_res.linear_x_out    <= '0;
                        r_res.forward_stopped <= 1'b1;
                    end else if (!r_lat_found) begin
                        r_res.linear_x_out    <= r_lin;
                        r_res.forward_stopped <= 1'b0;
                    end else if (r_lat_near <= r_stop) begin
                        r_res.linear_x_out    <= '0;
                        r_res.forward_stopped <= 1'b1;
                    end else if ((r_lat_near < r_slow) && (r_slow > r_stop)) begin
                        r_state <= S_CMUL;
                    end else begin
                        r_res.linear_x_out    <= r_lin;
                        r_res.forward_stopped <= 1'b0;
                    end
                end
                S_CMUL: begin
                    r_num   <= NUM_W'(r_lin[SPD_W-2:0]) * NUM_W'(r_lat_near - r_stop);
                    r_den   <= r_slow - r_stop;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_CDIV;
                end
                S_CDIV: begin
                    r_num <= num_nx;
                    r_rem <= rem_nx;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == DIV_LAST) begin
                        r_res.linear_x_out    <= num_nx[SPD_W-1:0];
                        r_res.forward_stopped <= (num_nx == '0);
                        r_state               <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CDIV) |-> (r_den != '0))
        else $error("divide with zero band");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CDIV) |-> (r_rem < r_den))
        else $error("divider remainder out of range");

    a_report_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.result_kind == RES_REPORT) |->
        (o_out_data.linear_x_out == '0 && !o_out_data.forward_stopped))
        else $error("report carries command fields");

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.forward_stopped) |-> (o_out_data.linear_x_out == '0))
        else $error("stopped command with nonzero speed");

endmodule
